// ===== hdl/first_fit_arena_allocator_core_defines.svh =====
// Assertion macros used by the allocator core RTL.
`ifndef FIRST_FIT_ARENA_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_CORE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define FFA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("allocator check failed");

// Checks that a condition implies another one in the next cycle.
`define FFA_ASSERT_NEXT(label, cond, nxt) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error("allocator sequencing check failed");

`endif

// ===== hdl/ffa_pkg.sv =====
// Package with codes and default sizes of the first-fit arena allocator.
`default_nettype none
package ffa_pkg;

  localparam int ARENA_BYTES_DEF  = 4096;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int MAX_BLOCKS_DEF   = 256;

  localparam int OFS_W = 12;
  localparam int OUT_W = 9;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FREED    = 3'd4
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

endpackage
`default_nettype wire

// ===== hdl/ffa_table.sv =====
// Block table memory with one write port and one registered read port.
`default_nettype none
module ffa_table #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8,
  parameter int ENT_W = 14
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [ENT_W-1:0] wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [ENT_W-1:0] rdata_o
);
  logic [ENT_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/first_fit_arena_allocator_core.sv =====
// Top level of the first-fit arena allocator: sequencer, walk adder and result register.
// Sequence: an allocate reads and checks each block in S_RD and S_EV and loads the result in S_DONE;
// a split moves entries up through S_UR and S_UW. A free reads the next block in S_NRD and S_NEV,
// merges in S_MG and S_MW, and moves entries down through S_DR and S_DW when entries move.
// One request is in work at a time; s_axis_tready is high only in the idle state.
// Reset is asynchronous and active low; the S_INIT state after reset writes the first table entry.
`default_nettype none
`include "first_fit_arena_allocator_core_defines.svh"
module first_fit_arena_allocator_core #(
  parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // req_size[11:0], address[23:12]
  input  wire logic        s_axis_tuser,  // cmd[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata   // status[2:0], payload_offset[14:3], outstanding[23:15]
);
  import ffa_pkg::*;

  localparam int LEN_W = $clog2(ARENA_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int POS_W = ((LEN_W > OFS_W) ? LEN_W : OFS_W) + 2;
  localparam int ENT_W = LEN_W + 1;
  localparam logic [POS_W-1:0] HDR = POS_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MAXB = CNT_W'(MAX_BLOCKS);

  typedef enum logic [12:0] {
    S_INIT = 13'h0001, S_IDLE = 13'h0002, S_RD  = 13'h0004, S_EV  = 13'h0008,
    S_NRD  = 13'h0010, S_NEV  = 13'h0020, S_MG  = 13'h0040, S_MW  = 13'h0080,
    S_DR   = 13'h0100, S_DW   = 13'h0200, S_UR  = 13'h0400, S_UW  = 13'h0800,
    S_DONE = 13'h1000
  } state_e;

  state_e            state_q, state_d;
  logic              cmd_q, cmd_d;
  logic [OFS_W-1:0]  size_q, size_d, addr_q, addr_d, ofs_q, ofs_d;
  logic [CNT_W-1:0]  idx_q, idx_d, total_q, total_d, j_q, j_d, mtgt_q, mtgt_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [OUT_W-1:0]  grant_q, grant_d, rel_q, rel_d;
  logic [LEN_W-1:0]  cur_q, cur_d, prev_q, prev_d, next_q, next_d, mlen_q, mlen_d;
  logic              prevf_q, prevf_d, nextf_q, nextf_d;
  logic [1:0]        k_q, k_d;
  status_e           st_q, st_d;
  logic              mv_q, mv_d;
  logic [23:0]       mdata_q, mdata_d;

  logic             we;
  logic [CNT_W-1:0] waddr, raddr;
  logic [ENT_W-1:0] wdata, rdata;
  logic [LEN_W-1:0] rlen;
  logic             rfree;
  logic [POS_W-1:0] rlen_x, size_x, step_sum, msum;
  logic             pf;

  assign rlen   = rdata[LEN_W-1:0];
  assign rfree  = rdata[LEN_W];
  assign rlen_x = POS_W'(rlen);
  assign size_x = POS_W'(size_q);
  assign step_sum = pos_q + rlen_x + HDR;
  assign pf = (idx_q != '0) && prevf_q;

  always_comb begin
    msum = POS_W'(cur_q);
    if (pf) msum = msum + POS_W'(prev_q) + HDR;
    if (nextf_q) msum = msum + POS_W'(next_q) + HDR;
  end

  ffa_table #(.DEPTH(MAX_BLOCKS), .IDX_W(IDX_W), .ENT_W(ENT_W)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; size_d = size_q; addr_d = addr_q; ofs_d = ofs_q;
    idx_d = idx_q; total_d = total_q; j_d = j_q; mtgt_d = mtgt_q; pos_d = pos_q;
    grant_d = grant_q; rel_d = rel_q; cur_d = cur_q; prev_d = prev_q; next_d = next_q;
    mlen_d = mlen_q; prevf_d = prevf_q; nextf_d = nextf_q; k_d = k_q;
    st_d = st_q; mdata_d = mdata_q;
    mv_d = mv_q && !m_axis_tready;
    we = 1'b0; waddr = '0; wdata = '0; raddr = idx_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_INIT: begin
        we = 1'b1;
        wdata = {1'b1, LEN_W'(ARENA_BYTES - HEADER_BYTES)};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_d = s_axis_tuser;
          size_d = s_axis_tdata[11:0];
          addr_d = s_axis_tdata[23:12];
          ofs_d = '0; idx_d = '0; pos_d = HDR; prevf_d = 1'b0; nextf_d = 1'b0;
          if (s_axis_tuser == CMD_ALLOC && s_axis_tdata[11:0] == '0) begin
            st_d = ST_ZERO;
            state_d = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_q >= total_q) begin
          st_d = (cmd_q == CMD_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          state_d = S_EV;
        end
      end
      S_EV: begin
        state_d = S_RD;
        if (cmd_q == CMD_ALLOC) begin
          if (rfree && rlen_x >= size_x) begin
            grant_d = grant_q + 1'b1;
            ofs_d = pos_q[OFS_W-1:0];
            st_d = ST_OK;
            we = 1'b1; waddr = idx_q;
            if ((rlen_x - size_x) >= HDR && total_q < MAXB) begin
              wdata = {1'b0, LEN_W'(size_q)};
              mlen_d = LEN_W'(rlen_x - size_x - HDR);
              j_d = total_q - 1'b1;
              state_d = S_UR;
            end else begin
              wdata = {1'b0, rlen};
              state_d = S_DONE;
            end
          end else begin
            pos_d = step_sum;
            idx_d = idx_q + 1'b1;
          end
        end else if (pos_q == POS_W'(addr_q)) begin
          cur_d = rlen;
          if (rfree) begin
            st_d = ST_FREED;
            state_d = S_DONE;
          end else if (idx_q + 1'b1 < total_q) begin
            state_d = S_NRD;
          end else begin
            state_d = S_MG;
          end
        end else begin
          prev_d = rlen; prevf_d = rfree;
          pos_d = step_sum;
          idx_d = idx_q + 1'b1;
        end
      end
      S_NRD: begin
        raddr = idx_q + 1'b1;
        state_d = S_NEV;
      end
      S_NEV: begin
        next_d = rlen; nextf_d = rfree;
        state_d = S_MG;
      end
      S_MG: begin
        mlen_d = LEN_W'(msum);
        mtgt_d = pf ? idx_q - 1'b1 : idx_q;
        k_d = 2'(pf) + 2'(nextf_q);
        j_d = idx_q + (nextf_q ? CNT_W'(2) : CNT_W'(1));
        rel_d = rel_q + 1'b1;
        st_d = ST_OK;
        state_d = S_MW;
      end
      S_MW: begin
        we = 1'b1; waddr = mtgt_q; wdata = {1'b1, mlen_q};
        state_d = (k_q == 2'd0) ? S_DONE : S_DR;
      end
      S_DR: begin
        raddr = j_q;
        if (j_q >= total_q) begin
          total_d = total_q - CNT_W'(k_q);
          state_d = S_DONE;
        end else begin
          state_d = S_DW;
        end
      end
      S_DW: begin
        we = 1'b1; waddr = j_q - CNT_W'(k_q); wdata = rdata;
        j_d = j_q + 1'b1;
        state_d = S_DR;
      end
      S_UR: begin
        raddr = j_q;
        if (j_q == idx_q) begin
          we = 1'b1; waddr = idx_q + 1'b1; wdata = {1'b1, mlen_q};
          total_d = total_q + 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_UW;
        end
      end
      S_UW: begin
        we = 1'b1; waddr = j_q + 1'b1; wdata = rdata;
        j_d = j_q - 1'b1;
        state_d = S_UR;
      end
      S_DONE: begin
        if (!mv_q || m_axis_tready) begin
          mv_d = 1'b1;
          mdata_d = {grant_q - rel_q, ofs_q, st_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      total_q <= CNT_W'(1);
      grant_q <= '0;
      rel_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      grant_q <= grant_d;
      rel_q   <= rel_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; size_q <= size_d; addr_q <= addr_d; ofs_q <= ofs_d;
    idx_q <= idx_d; j_q <= j_d; mtgt_q <= mtgt_d; pos_q <= pos_d;
    cur_q <= cur_d; prev_q <= prev_d; next_q <= next_d; mlen_q <= mlen_d;
    prevf_q <= prevf_d; nextf_q <= nextf_d; k_q <= k_d;
    st_q <= st_d; mdata_q <= mdata_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;

  `FFA_ASSERT(a_total_range, (total_q != '0) && (total_q <= MAXB))
  `FFA_ASSERT(a_fail_no_ofs, !mv_q || mdata_q[2:0] == ST_OK || mdata_q[14:3] == '0)
  `FFA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the first-fit arena allocator: directed table, fill phase and random traffic.
`default_nettype none
module tb_top;
  import ffa_pkg::*;

  localparam int ARENA  = ARENA_BYTES_DEF;
  localparam int HDR    = HEADER_BYTES_DEF;
  localparam int NBLK   = MAX_BLOCKS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1100;

  typedef struct packed {
    status_e          status;
    logic [OFS_W-1:0] offset;
    logic [OUT_W-1:0] outstanding;
  } grant_t;

  typedef struct {
    cmd_e             cmd;
    logic [11:0]      size;
    logic [11:0]      addr;
    bit               typed;
    grant_t           want;
  } req_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  first_fit_arena_allocator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block table.
  int unsigned      blk_len [NBLK];
  bit               blk_free[NBLK];
  int unsigned      blk_cnt;
  logic [OUT_W-1:0] grants;
  logic [OUT_W-1:0] releases;

  grant_t pending_grants[$];
  int     mismatches = 0;
  bit     stim_done = 1'b0;
  int     idle_cycles = 0;

  function automatic void drop_block(int unsigned j);
    for (int unsigned k = j; k + 1 < blk_cnt; k++) begin
      blk_len[k]  = blk_len[k+1];
      blk_free[k] = blk_free[k+1];
    end
    blk_cnt--;
  endfunction

  function automatic grant_t predict_grant(cmd_e cmd, logic [11:0] size, logic [11:0] addr);
    grant_t      g;
    int unsigned pos;
    int unsigned len;
    int unsigned i;
    g.status = ST_NOSPACE;
    g.offset = '0;
    pos = HDR;
    if (cmd == CMD_ALLOC) begin
      if (size == 0) begin
        g.status = ST_ZERO;
      end else begin
        for (i = 0; i < blk_cnt; i++) begin
          len = blk_len[i];
          if (blk_free[i] && len >= size) begin
            if (len - size >= HDR && blk_cnt < NBLK) begin
              for (int unsigned k = blk_cnt; k > i + 1; k--) begin
                blk_len[k]  = blk_len[k-1];
                blk_free[k] = blk_free[k-1];
              end
              blk_len[i+1]  = len - size - HDR;
              blk_free[i+1] = 1'b1;
              blk_cnt++;
              blk_len[i] = size;
            end
            blk_free[i] = 1'b0;
            grants++;
            g.status = ST_OK;
            g.offset = pos[OFS_W-1:0];
            break;
          end
          pos += len + HDR;
        end
      end
    end else begin
      for (i = 0; i < blk_cnt; i++) begin
        if (pos == addr) break;
        pos += blk_len[i] + HDR;
      end
      if (i >= blk_cnt) begin
        g.status = ST_NOTFOUND;
      end else if (blk_free[i]) begin
        g.status = ST_FREED;
      end else begin
        blk_free[i] = 1'b1;
        if (i > 0 && blk_free[i-1]) begin
          blk_len[i-1] += HDR + blk_len[i];
          drop_block(i);
          i--;
        end
        if (i + 1 < blk_cnt && blk_free[i+1]) begin
          blk_len[i] += HDR + blk_len[i+1];
          drop_block(i + 1);
        end
        releases++;
        g.status = ST_OK;
      end
    end
    g.outstanding = grants - releases;
    return g;
  endfunction

  // Payload offset of a block in use (want_busy) or free, picked at random; -1 if none.
  function automatic int pick_block(bit want_busy);
    int          hits[$];
    int unsigned pos;
    pos = HDR;
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      if (blk_free[i] != want_busy) hits.push_back(pos);
      pos += blk_len[i] + HDR;
    end
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  function automatic int draw_gap();
    if ($urandom_range(9) < 3) return 0;
    return $urandom_range(18);
  endfunction

  task automatic send(cmd_e cmd, logic [11:0] size, logic [11:0] addr, bit typed, grant_t want);
    int     gap;
    grant_t g;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {addr, size};
    do @(posedge clk_i); while (!s_axis_tready);
    g = predict_grant(cmd, size, addr);
    pending_grants.push_back(typed ? want : g);
  endtask

  task automatic send_pred(cmd_e cmd, logic [11:0] size, logic [11:0] addr);
    send(cmd, size, addr, 1'b0, '0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    req_row_t rows[$];
    int       a;
    int       roll;
    rows.push_back('{CMD_ALLOC, 12'd0,    12'd4095, 1'b1, '{ST_ZERO,     12'd0,  9'd0}});
    rows.push_back('{CMD_ALLOC, 12'd4095, 12'd0,    1'b1, '{ST_NOSPACE,  12'd0,  9'd0}});
    rows.push_back('{CMD_FREE,  12'd4095, 12'd0,    1'b1, '{ST_NOTFOUND, 12'd0,  9'd0}});
    rows.push_back('{CMD_FREE,  12'd0,    12'd16,   1'b1, '{ST_FREED,    12'd0,  9'd0}});
    rows.push_back('{CMD_ALLOC, 12'd4080, 12'd0,    1'b1, '{ST_OK,       12'd16, 9'd1}});
    rows.push_back('{CMD_ALLOC, 12'd1,    12'd0,    1'b1, '{ST_NOSPACE,  12'd0,  9'd1}});
    rows.push_back('{CMD_FREE,  12'd0,    12'd16,   1'b1, '{ST_OK,       12'd0,  9'd0}});
    rows.push_back('{CMD_ALLOC, 12'd4064, 12'd2730, 1'b1, '{ST_OK,       12'd16, 9'd1}});
    rows.push_back('{CMD_ALLOC, 12'd1,    12'd0,    1'b1, '{ST_NOSPACE,  12'd0,  9'd1}});
    rows.push_back('{CMD_FREE,  12'd4095, 12'd4095, 1'b1, '{ST_NOTFOUND, 12'd0,  9'd1}});
    rows.push_back('{CMD_FREE,  12'd0,    12'd16,   1'b1, '{ST_OK,       12'd0,  9'd0}});
    rows.push_back('{CMD_ALLOC, 12'd100,  12'd0,    1'b0, '0});
    rows.push_back('{CMD_ALLOC, 12'd200,  12'd0,    1'b0, '0});
    rows.push_back('{CMD_ALLOC, 12'd300,  12'd0,    1'b0, '0});
    rows.push_back('{CMD_FREE,  12'd0,    12'd132,  1'b0, '0});
    rows.push_back('{CMD_FREE,  12'd0,    12'd16,   1'b0, '0});
    rows.push_back('{CMD_ALLOC, 12'd50,   12'd0,    1'b0, '0});
    rows.push_back('{CMD_FREE,  12'd2730, 12'd348,  1'b0, '0});
    rows.push_back('{CMD_ALLOC, 12'd4095, 12'd4095, 1'b0, '0});
    rows.push_back('{CMD_FREE,  12'd0,    12'd4095, 1'b0, '0});

    blk_len[0]  = ARENA - HDR;
    blk_free[0] = 1'b1;
    blk_cnt     = 1;
    grants      = '0;
    releases    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[r]) send(rows[r].cmd, rows[r].size, rows[r].addr, rows[r].typed, rows[r].want);

    // Hold off until the result stream is empty, then rebuild a single free block.
    wait_drained();
    for (a = pick_block(1'b1); a >= 0; a = pick_block(1'b1)) begin
      send_pred(CMD_FREE, 12'($urandom), 12'(a));
    end

    // Fill the arena with tiny blocks, then free neighboring pairs and reallocate them so that
    // merges and splits run over a long table.
    repeat ((ARENA - HDR) / (HDR + 1)) send_pred(CMD_ALLOC, 12'd1, 12'($urandom));
    for (int k = 0; k < 110; k++) begin
      send_pred(CMD_FREE, 12'($urandom), 12'(HDR + 34 * k));
      send_pred(CMD_FREE, 12'($urandom), 12'(HDR + 34 * k + 17));
      send_pred(CMD_ALLOC, 12'd2, 12'($urandom));
    end
    for (a = pick_block(1'b1); a >= 0; a = pick_block(1'b1)) begin
      send_pred(CMD_FREE, 12'($urandom), 12'(a));
    end

    repeat (280) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        roll = $urandom_range(9);
        send_pred(CMD_ALLOC, roll < 7 ? 12'($urandom_range(64, 1)) :
                             roll < 9 ? 12'($urandom_range(1024, 65)) : 12'($urandom),
                  12'($urandom));
      end else if (roll < 85 && pick_block(1'b1) >= 0) begin
        send_pred(CMD_FREE, 12'($urandom), 12'(pick_block(1'b1)));
      end else if (roll < 92 && pick_block(1'b0) >= 0) begin
        send_pred(CMD_FREE, 12'($urandom), 12'(pick_block(1'b0)));
      end else begin
        send_pred(roll[0] ? CMD_FREE : CMD_ALLOC, 12'($urandom), 12'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int     gap;
    grant_t want;
    grant_t got;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = grant_t'({m_axis_tdata[2:0], m_axis_tdata[14:3], m_axis_tdata[23:15]});
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", m_axis_tdata);
      end else begin
        want = pending_grants.pop_front();
        if (got.status != want.status || got.offset != want.offset ||
            got.outstanding != want.outstanding) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d offset %0d outstanding %0d, got %0d %0d %0d",
                     want.status, want.offset, want.outstanding,
                     got.status, got.offset, got.outstanding);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_table.sv
hdl/first_fit_arena_allocator_core.sv
sim/tb_top.sv
